// ===== hw/rtl/okvt_pkg.sv =====
package okvt_pkg;

    localparam int REQ_TYPE_W    = 2;
    localparam int REQ_KEY_W     = 32;
    localparam int REQ_VALUE_W   = 32;
    localparam int RSP_COUNT_W   = 7;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ACCESS = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_ERASE  = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_SHIFT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic val_we;
    } t_mem_ctl;

endpackage

// ===== hw/rtl/okvt_req_if.sv =====
interface okvt_req_if import okvt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [REQ_KEY_W-1:0]   req_key;
    logic [REQ_VALUE_W-1:0] write_value;

    modport source (output valid, output req_type, output req_key, output write_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input write_value,
                    output ready);
endinterface

// ===== hw/rtl/okvt_rsp_if.sv =====
interface okvt_rsp_if import okvt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REQ_VALUE_W-1:0] read_value;
    logic                   key_found;
    logic                   table_full;
    logic [RSP_COUNT_W-1:0] entry_count;

    modport source (output valid, output read_value, output key_found, output table_full,
                    output entry_count, input ready);
    modport sink   (input valid, input read_value, input key_found, input table_full,
                    input entry_count, output ready);
endinterface

// ===== hw/rtl/ordered_key_value_table.sv =====
// Insertion-ordered key/value table.
// Request channel i_req carries req_type, req_key and write_value; response
// channel o_rsp returns read_value, key_found, table_full and entry_count.
// Both use valid/ready; an item moves when both are high at a clock edge.
// One response per request, in request order; one request is in work at a time.
// Keys and values sit in a single-port-read, single-port-write synchronous
// memory, so a lookup walks the live entries one per cycle.
// Each request: the scan reads entries from position 0 upward until the
// key matches or the live entries run out (an empty table skips it); a
// miss by an access or write inserts the key at the end if there is room,
// and an erase hit moves each later entry down one place. The response
// register is then loaded, and the block goes idle to take the next request.
// The response register lets a new request start while the last response
// still waits; a stalled receiver holds the response and the block waits
// with the next one finished until the register frees.
// Reset empties the table at once (entry count zero); no clearing pass.
module ordered_key_value_table import okvt_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okvt_req_if.sink   i_req,
    okvt_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    t_mem_ctl               mem_ctl;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;

    okvt_ctrl #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_ctl     (mem_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .o_wr_key  (wr_key),
        .o_wr_val  (wr_val),
        .i_rd_key  (rd_key),
        .i_rd_val  (rd_val)
    );

    okvt_store #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_val  (wr_val),
        .o_rd_key  (rd_key),
        .o_rd_val  (rd_val)
    );

endmodule

// ===== hw/rtl/okvt_store.sv =====
module okvt_store import okvt_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int AW         = $clog2(CAPACITY)
) (
    input  logic                   i_clk,
    input  t_mem_ctl               i_ctl,
    input  logic [AW-1:0]          i_rd_addr,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [KEY_WIDTH-1:0]   i_wr_key,
    input  logic [VALUE_WIDTH-1:0] i_wr_val,
    output logic [KEY_WIDTH-1:0]   o_rd_key,
    output logic [VALUE_WIDTH-1:0] o_rd_val
);

    logic [KEY_WIDTH-1:0]   r_key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [VALUE_WIDTH-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_ctl.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        if (i_ctl.rd_en) begin
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

// ===== hw/rtl/okvt_ctrl.sv =====
module okvt_ctrl import okvt_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int AW         = $clog2(CAPACITY),
    localparam int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    okvt_req_if.sink               i_req,
    okvt_rsp_if.source             o_rsp,
    output t_mem_ctl               o_ctl,
    output logic [AW-1:0]          o_rd_addr,
    output logic [AW-1:0]          o_wr_addr,
    output logic [KEY_WIDTH-1:0]   o_wr_key,
    output logic [VALUE_WIDTH-1:0] o_wr_val,
    input  logic [KEY_WIDTH-1:0]   i_rd_key,
    input  logic [VALUE_WIDTH-1:0] i_rd_val
);

    t_state                 r_state, n_state;
    t_req_type              r_type, n_type;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_wval, n_wval;
    logic [AW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_count, n_count;
    logic [VALUE_WIDTH-1:0] r_res_value, n_res_value;
    logic                   r_res_found, n_res_found;
    logic                   r_res_full, n_res_full;
    logic                   r_out_valid, n_out_valid;
    logic [REQ_VALUE_W-1:0] r_out_value, n_out_value;
    logic                   r_out_found, n_out_found;
    logic                   r_out_full, n_out_full;
    logic [RSP_COUNT_W-1:0] r_out_count, n_out_count;

    logic [KEY_WIDTH+REQ_KEY_W-1:0]     key_ext;
    logic [VALUE_WIDTH+REQ_VALUE_W-1:0] wval_ext;
    logic [VALUE_WIDTH+REQ_VALUE_W-1:0] res_ext;
    logic [CW+RSP_COUNT_W-1:0]          count_ext;
    logic [CW:0]                        count_w;
    logic [CW:0]                        idx_p1;
    logic [CW:0]                        idx_p2;
    logic                               has_room;
    logic [VALUE_WIDTH-1:0]             ins_val;

    assign key_ext   = {{KEY_WIDTH{1'b0}}, i_req.req_key};
    assign wval_ext  = {{VALUE_WIDTH{1'b0}}, i_req.write_value};
    assign res_ext   = {{REQ_VALUE_W{1'b0}}, r_res_value};
    assign count_ext = {{RSP_COUNT_W{1'b0}}, r_count};
    assign count_w   = (CW + 1)'(r_count);
    assign idx_p1    = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign idx_p2    = (CW + 1)'(r_idx) + (CW + 1)'(2);
    assign has_room  = (r_count != CW'(CAPACITY));
    assign ins_val   = (r_type == REQ_WRITE) ? r_wval : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type      <= n_type;
        r_key       <= n_key;
        r_wval      <= n_wval;
        r_idx       <= n_idx;
        r_res_value <= n_res_value;
        r_res_found <= n_res_found;
        r_res_full  <= n_res_full;
        r_out_value <= n_out_value;
        r_out_found <= n_out_found;
        r_out_full  <= n_out_full;
        r_out_count <= n_out_count;
    end

    always_comb begin
        n_state     = r_state;
        n_type      = r_type;
        n_key       = r_key;
        n_wval      = r_wval;
        n_idx       = r_idx;
        n_count     = r_count;
        n_res_value = r_res_value;
        n_res_found = r_res_found;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        n_out_found = r_out_found;
        n_out_full  = r_out_full;
        n_out_count = r_out_count;
        o_ctl       = '0;
        o_rd_addr   = r_idx;
        o_wr_addr   = r_idx;
        o_wr_key    = r_key;
        o_wr_val    = r_wval;
        i_req.ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_type = t_req_type'(i_req.req_type);
                    n_key  = key_ext[KEY_WIDTH-1:0];
                    n_wval = wval_ext[VALUE_WIDTH-1:0];
                    n_idx  = '0;
                    if (r_count == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = '0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_rd_key == r_key) begin
                    n_res_found = 1'b1;
                    n_res_full  = 1'b0;
                    n_state     = ST_OUT;
                    case (r_type)
                        REQ_WRITE: begin
                            o_ctl.val_we = 1'b1;
                            n_res_value  = r_wval;
                        end
                        REQ_ERASE: begin
                            n_res_value = '0;
                            if (idx_p1 < count_w) begin
                                o_ctl.rd_en = 1'b1;
                                o_rd_addr   = AW'(idx_p1);
                                n_state     = ST_SHIFT;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_res_value = i_rd_val;
                        end
                    endcase
                end else if (idx_p1 == count_w) begin
                    n_state = ST_MISS;
                end else begin
                    n_idx       = AW'(idx_p1);
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = AW'(idx_p1);
                end
            end
            ST_MISS: begin
                n_res_found = 1'b0;
                n_res_full  = 1'b0;
                n_res_value = '0;
                n_state     = ST_OUT;
                if (r_type == REQ_ACCESS || r_type == REQ_WRITE) begin
                    if (has_room) begin
                        o_ctl.key_we = 1'b1;
                        o_ctl.val_we = 1'b1;
                        o_wr_addr    = AW'(r_count);
                        o_wr_val     = ins_val;
                        n_res_value  = ins_val;
                        n_count      = r_count + CW'(1);
                    end else begin
                        n_res_full = 1'b1;
                    end
                end
            end
            ST_SHIFT: begin
                o_ctl.key_we = 1'b1;
                o_ctl.val_we = 1'b1;
                o_wr_key     = i_rd_key;
                o_wr_val     = i_rd_val;
                if (idx_p2 < count_w) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = AW'(idx_p2);
                    n_idx       = AW'(idx_p1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = res_ext[REQ_VALUE_W-1:0];
                    n_out_found = r_res_found;
                    n_out_full  = r_res_full;
                    n_out_count = count_ext[RSP_COUNT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.key_found   = r_out_found;
    assign o_rsp.table_full  = r_out_full;
    assign o_rsp.entry_count = r_out_count;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import okvt_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int KEY_POOL_N  = 96;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [REQ_VALUE_W-1:0] value;
        logic                   found;
        logic                   full;
        logic [RSP_COUNT_W-1:0] count;
    } t_table_rsp;

    logic i_clk;
    logic i_rst_n;

    okvt_req_if u_req_if ();
    okvt_rsp_if u_rsp_if ();

    ordered_key_value_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req_if),
        .o_rsp   (u_rsp_if)
    );

    logic [REQ_KEY_W-1:0]   tbl_keys [CAPACITY];
    logic [REQ_VALUE_W-1:0] tbl_vals [CAPACITY];
    int                     tbl_count;
    logic [REQ_KEY_W-1:0]   key_pool [KEY_POOL_N];

    t_table_rsp pending_rsp [$];

    int send_idle_pct;
    int recv_idle_pct;
    int rsp_hold_cycles;
    int error_count;
    int request_count;
    int result_count;
    int cycle_count;
    int hit_count;
    int refused_count;
    int erase_count;
    int peak_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_rsp.size());
            $display("ordered_key_value_table regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] result %0d: %s", $realtime, result_count, msg);
        error_count++;
    endtask

    function automatic t_table_rsp apply_request(t_req_type kind,
                                                 logic [REQ_KEY_W-1:0] key,
                                                 logic [REQ_VALUE_W-1:0] wval);
        t_table_rsp rsp;
        int pos;
        int i;
        rsp = '0;
        pos = -1;
        for (i = 0; i < tbl_count; i++) begin
            if (pos < 0 && tbl_keys[i] == key) pos = i;
        end
        rsp.found = (pos >= 0);
        if (pos >= 0) hit_count++;
        case (kind)
            REQ_ACCESS, REQ_WRITE: begin
                if (pos < 0) begin
                    if (tbl_count < CAPACITY) begin
                        pos = tbl_count;
                        tbl_keys[pos] = key;
                        tbl_vals[pos] = '0;
                        tbl_count++;
                    end else begin
                        rsp.full = 1'b1;
                        refused_count++;
                    end
                end
                if (pos >= 0) begin
                    if (kind == REQ_WRITE) tbl_vals[pos] = wval;
                    rsp.value = tbl_vals[pos];
                end
            end
            REQ_READ: begin
                if (pos >= 0) rsp.value = tbl_vals[pos];
            end
            default: begin
                if (pos >= 0) begin
                    for (i = pos; i + 1 < tbl_count; i++) begin
                        tbl_keys[i] = tbl_keys[i + 1];
                        tbl_vals[i] = tbl_vals[i + 1];
                    end
                    tbl_count--;
                    erase_count++;
                end
            end
        endcase
        if (tbl_count > peak_count) peak_count = tbl_count;
        rsp.count = RSP_COUNT_W'(tbl_count);
        return rsp;
    endfunction

    always @(posedge i_clk) begin : rsp_monitor
        t_table_rsp want;
        if (i_rst_n && u_rsp_if.valid && u_rsp_if.ready) begin
            result_count++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("item with no request outstanding");
            end else begin
                want = pending_rsp.pop_front();
                if (u_rsp_if.read_value !== want.value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              u_rsp_if.read_value, want.value));
                if (u_rsp_if.key_found !== want.found)
                    report_mismatch($sformatf("key_found %b, want %b",
                                              u_rsp_if.key_found, want.found));
                if (u_rsp_if.table_full !== want.full)
                    report_mismatch($sformatf("table_full %b, want %b",
                                              u_rsp_if.table_full, want.full));
                if (u_rsp_if.entry_count !== want.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              u_rsp_if.entry_count, want.count));
            end
        end
        if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            u_rsp_if.ready <= 1'b0;
        end else begin
            u_rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(t_req_type kind, logic [REQ_KEY_W-1:0] key,
                                logic [REQ_VALUE_W-1:0] wval);
        while ($urandom_range(99) < send_idle_pct) begin
            u_req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_req_if.valid       <= 1'b1;
        u_req_if.req_type    <= kind;
        u_req_if.req_key     <= key;
        u_req_if.write_value <= wval;
        @(posedge i_clk);
        while (!u_req_if.ready) @(posedge i_clk);
        request_count++;
        pending_rsp.push_back(apply_request(kind, key, wval));
    endtask

    task automatic wait_for_results();
        u_req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [REQ_KEY_W-1:0] pick_key(int span);
        if ($urandom_range(99) < 80) return key_pool[$urandom_range(span - 1)];
        return $urandom;
    endfunction

    task automatic run_directed_cases();
        send_request(REQ_READ,   32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_ERASE,  32'h0000_0000, 32'h0000_0000);
        send_request(REQ_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_WRITE,  32'h0000_0000, 32'h5A5A_5A5A);
        send_request(REQ_READ,   32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_ACCESS, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(REQ_WRITE,  32'hA5A5_A5A5, 32'h0000_0000);
        send_request(REQ_WRITE,  32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_request(REQ_ERASE,  32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_READ,   32'h0000_0000, 32'h0000_0000);
        send_request(REQ_READ,   32'h5A5A_5A5A, 32'h0000_0000);
        send_request(REQ_ERASE,  32'h5A5A_5A5A, 32'h0000_0000);
        send_request(REQ_ERASE,  32'h5A5A_5A5A, 32'h0000_0000);
        send_request(REQ_ACCESS, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_READ,   32'hA5A5_A5A5, 32'h0000_0000);
        wait_for_results();
    endtask

    task automatic run_capacity_cases();
        while (tbl_count < CAPACITY) send_request(REQ_WRITE, $urandom, $urandom);
        send_request(REQ_ACCESS, $urandom, $urandom);
        send_request(REQ_WRITE, $urandom, $urandom);
        send_request(REQ_READ, $urandom, $urandom);
        send_request(REQ_ACCESS, tbl_keys[CAPACITY - 1], $urandom);
        send_request(REQ_WRITE, tbl_keys[CAPACITY - 1], $urandom);
        send_request(REQ_ERASE, tbl_keys[0], $urandom);
        send_request(REQ_WRITE, $urandom, $urandom);
        send_request(REQ_ERASE, tbl_keys[CAPACITY / 2], $urandom);
        send_request(REQ_ERASE, tbl_keys[tbl_count - 1], $urandom);
        send_request(REQ_ACCESS, $urandom, $urandom);
        send_request(REQ_READ, tbl_keys[0], $urandom);
        while (tbl_count > 0) send_request(REQ_ERASE, tbl_keys[$urandom_range(tbl_count - 1)],
                                           $urandom);
        wait_for_results();
    endtask

    task automatic run_random_traffic(int n, int span);
        repeat (n) send_request(t_req_type'($urandom_range(3)), pick_key(span), $urandom);
        wait_for_results();
    endtask

    task automatic run_backpressure();
        rsp_hold_cycles = 400;
        repeat (16) send_request(t_req_type'($urandom_range(3)), pick_key(32), $urandom);
        wait_for_results();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        u_req_if.valid       <= 1'b0;
        u_req_if.req_type    <= REQ_ACCESS;
        u_req_if.req_key     <= '0;
        u_req_if.write_value <= '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 52;
        run_directed_cases();
        run_capacity_cases();
        run_random_traffic(290, 24);

        send_idle_pct = 52;
        recv_idle_pct = 37;
        run_random_traffic(290, KEY_POOL_N);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_backpressure();
        run_random_traffic(290, 72);

        wait_for_results();
        repeat (3 * CAPACITY) @(posedge i_clk);

        $display("%0d requests, %0d results checked: %0d hits, %0d erases, %0d refused inserts",
                 request_count, result_count, hit_count, erase_count, refused_count);
        $display("table filled to %0d entries, emptied, and driven under three stall mixes",
                 peak_count);
        if (error_count == 0 && pending_rsp.size() == 0) begin
            $display("ordered_key_value_table regression: pass");
        end else begin
            $display("ordered_key_value_table regression: fail");
        end
        $finish;
    end

endmodule
